FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/epi_pkg.sv
// ----------------------------------------------------------------------------
// epi_pkg
// Shared constants, status codes and sine-squared table function.
// ----------------------------------------------------------------------------
package epi_pkg;

  localparam int NUM_STEPS_DEF = 1024;
  localparam int ROOT_W        = 17;
  localparam logic [63:0] HP30 = 64'd1686629713;
  localparam logic [27:0] PERIM_MAX = 28'hFFFFFFF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MAJOR_ZERO = 2'd1,
    ST_MINOR_GT   = 2'd2
  } status_t;

  // sin^2 in Q1.16 of angle x (Q2.30), Taylor series through x^17
  function automatic logic [16:0] sin2_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] sq;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    if (sum > 64'd1073741824) begin
      sum = 64'd1073741824;
    end
    sq = (sum * sum) >> 44;
    return sq[16:0];
  endfunction

endpackage

FILE: hdl/epi_sin2_rom.sv
// ----------------------------------------------------------------------------
// epi_sin2_rom
// Constant sin^2 table over the integration grid, registered read.
// ----------------------------------------------------------------------------
module epi_sin2_rom #(
  parameter int NUM_STEPS = epi_pkg::NUM_STEPS_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(NUM_STEPS+1)-1:0]   addr,
  output logic [epi_pkg::ROOT_W-1:0]       data_r
);

  localparam int AW    = $clog2(NUM_STEPS + 1);
  localparam int DEPTH = 2 ** AW;

  logic [epi_pkg::ROOT_W-1:0] rom_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [63:0] XANG = (64'(g) * epi_pkg::HP30) / NUM_STEPS;
    localparam logic [16:0] VAL  = (g <= NUM_STEPS) ? epi_pkg::sin2_q16(XANG) : 17'd0;
    assign rom_w[g] = VAL;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

FILE: hdl/epi_isqrt.sv
// ----------------------------------------------------------------------------
// epi_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module epi_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic        done,
  output logic [16:0] root
);

  `include "assert_macros.svh"

  logic [33:0] v_r, v_nxt;
  logic [18:0] rem_r, rem_nxt;
  logic [16:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [18:0] shifted;
  logic [18:0] trial;

  assign shifted = {rem_r[16:0], v_r[33:32]};
  assign trial   = {root_r, 2'b01};

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = {1'b0, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[31:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[15:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

  `EPI_ASSERT_NOW(a_sqrt_range, done_r, root_r <= 17'd65536, "isqrt root out of range")
  `EPI_ASSERT_NOW(a_sqrt_start_idle, start, !busy_r, "isqrt started while busy")

endmodule

FILE: hdl/epi_div.sv
// ----------------------------------------------------------------------------
// epi_div
// Restoring divider, 64-bit dividend by 48-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module epi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [63:0] quo
);

  `include "assert_macros.svh"

  logic [63:0] quo_r, quo_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;
  logic [48:0] diff;

  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[47:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[47:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

  `EPI_ASSERT_NOW(a_div_start_idle, start, !busy_r, "divider started while busy")

endmodule

FILE: hdl/ellipse_perimeter_integrator_unit.sv
// ----------------------------------------------------------------------------
// ellipse_perimeter_integrator_unit
// Ellipse perimeter 4*a*E(e) by trapezoid integration over a sin^2 table.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  in      | in_valid in_ready in_major_axis in_minor_axis | in
//  out     | out_valid out_ready out_perimeter out_status  | out
//
// Per item the sequencer runs the shared 17-step square root once per grid
// point, plus two 64-step divides.
// Error inputs skip to the last step. in_ready is high only in idle.
// A waiting result holds the sequencer in its last step until taken.
// Reset: synchronous, active low, clears sequencer and out_valid.
// ----------------------------------------------------------------------------
module ellipse_perimeter_integrator_unit #(
  parameter int NUM_STEPS = epi_pkg::NUM_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_major_axis,
  input  logic [23:0] in_minor_axis,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] out_perimeter,
  output logic [1:0]  out_status
);

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(NUM_STEPS + 1);
  localparam int SUM_W = epi_pkg::ROOT_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_STEPS);
  localparam logic [47:0]      STEPS_DEN = 48'(NUM_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_A, S_SQ_B, S_RDIV_GO, S_RDIV_WAIT, S_ROM, S_PMUL,
    S_SQRT_GO, S_SQRT_WAIT, S_EMUL, S_EDIV_GO, S_EDIV_WAIT, S_AMUL, S_FIN
  } state_t;

  state_t              state_r;
  logic [23:0]         a_r, b_r;
  epi_pkg::status_t    status_r;
  logic [47:0]         den_r;
  logic [63:0]         prod_r;
  logic [16:0]         e2_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic [17:0]         ell_r;
  logic                out_valid_r;
  logic [27:0]         out_perimeter_r;
  epi_pkg::status_t    out_status_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [47:0] div_den;
  logic        sqrt_start, sqrt_done;
  logic [32:0] radicand;
  logic [16:0] root;
  logic [16:0] rom_data;
  logic [18:0] prod_hi;
  logic [16:0] one_minus;
  logic [16:0] half_term;
  logic [16:0] ratio;
  logic [27:0] perim_val;

  always_comb begin
    unique case (state_r)
      S_SQ_A:  begin mul_a = 32'(a_r);   mul_b = 32'(a_r);    end
      S_SQ_B:  begin mul_a = 32'(b_r);   mul_b = 32'(b_r);    end
      S_PMUL:  begin mul_a = 32'(e2_r);  mul_b = 32'(rom_data); end
      S_EMUL:  begin mul_a = 32'(sum_r); mul_b = epi_pkg::HP30[31:0]; end
      S_AMUL:  begin mul_a = 32'(a_r);   mul_b = 32'(ell_r);  end
      default: begin mul_a = '0;         mul_b = '0;          end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign div_start = (state_r == S_RDIV_GO) || (state_r == S_EDIV_GO);
  assign div_num   = (state_r == S_RDIV_GO) ? {prod_r[47:0], 16'h0000} : prod_r;
  assign div_den   = (state_r == S_RDIV_GO) ? den_r : STEPS_DEN;

  assign prod_hi    = prod_r[34:16];
  assign one_minus  = (prod_hi < 19'd65536) ? 17'(19'd65536 - prod_hi) : 17'd0;
  assign radicand   = {one_minus, 16'h0000};
  assign sqrt_start = (state_r == S_SQRT_GO);
  assign half_term  = ((idx_r == '0) || (idx_r == LAST_IDX)) ? (root >> 1) : root;
  assign ratio      = (div_quo > 64'd65536) ? 17'd65536 : div_quo[16:0];
  assign perim_val  = (|prod_r[63:42]) ? epi_pkg::PERIM_MAX : prod_r[41:14];

  epi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  epi_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  epi_sin2_rom #(.NUM_STEPS(NUM_STEPS)) u_rom (
    .clk    (clk),
    .addr   (idx_r),
    .data_r (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r <= in_major_axis;
            b_r <= in_minor_axis;
            if (in_major_axis == '0) begin
              status_r <= epi_pkg::ST_MAJOR_ZERO;
              state_r  <= S_FIN;
            end else if (in_minor_axis > in_major_axis) begin
              status_r <= epi_pkg::ST_MINOR_GT;
              state_r  <= S_FIN;
            end else begin
              status_r <= epi_pkg::ST_OK;
              state_r  <= S_SQ_A;
            end
          end
        end
        S_SQ_A: begin
          prod_r  <= mul_p;
          state_r <= S_SQ_B;
        end
        S_SQ_B: begin
          den_r   <= prod_r[47:0];
          prod_r  <= mul_p;
          state_r <= S_RDIV_GO;
        end
        S_RDIV_GO: state_r <= S_RDIV_WAIT;
        S_RDIV_WAIT: begin
          if (div_done) begin
            e2_r    <= 17'd65536 - ratio;
            idx_r   <= '0;
            sum_r   <= '0;
            state_r <= S_ROM;
          end
        end
        S_ROM: state_r <= S_PMUL;
        S_PMUL: begin
          prod_r  <= mul_p;
          state_r <= S_SQRT_GO;
        end
        S_SQRT_GO: state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            sum_r <= sum_r + SUM_W'(half_term);
            if (idx_r == LAST_IDX) begin
              state_r <= S_EMUL;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_ROM;
            end
          end
        end
        S_EMUL: begin
          prod_r  <= mul_p;
          state_r <= S_EDIV_GO;
        end
        S_EDIV_GO: state_r <= S_EDIV_WAIT;
        S_EDIV_WAIT: begin
          if (div_done) begin
            ell_r   <= div_quo[47:30];
            state_r <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod_r  <= mul_p;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= status_r;
            out_perimeter_r <= (status_r == epi_pkg::ST_OK) ? perim_val : '0;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_perimeter = out_perimeter_r;
  assign out_status    = out_status_r;

  `EPI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "ready after accepted transfer")
  `EPI_ASSERT_NOW(a_err_zero, out_valid_r && (out_status_r != epi_pkg::ST_OK),
    out_perimeter_r == '0, "nonzero perimeter on error")

endmodule

FILE: verif/ellipse_perimeter_integrator_unit_test.sv
// ----------------------------------------------------------------------------
// ellipse_perimeter_integrator_unit_test
// Sends axis pairs through the valid/ready input with random gaps and drains
// perimeter/status results with random stalls. Each result is checked, in
// order, against typed rows or an in-bench fixed-point trapezoid integrator.
// ----------------------------------------------------------------------------
module ellipse_perimeter_integrator_unit_test;

  localparam int          STEPS      = epi_pkg::NUM_STEPS_DEF;
  localparam int          RAND_ITEMS = 100;
  localparam longint      MAX_CYCLES = 64'd12_000_000;
  localparam logic [63:0] UNIT30     = 64'd1 << 30;
  localparam logic [63:0] UNIT16     = 64'd65536;

  typedef struct packed {
    logic [27:0]      perimeter;
    epi_pkg::status_t status;
  } perim_res_t;

  typedef struct {
    logic [23:0] major;
    logic [23:0] minor;
    bit          typed;
    perim_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_major_axis = '0;
  logic [23:0] in_minor_axis = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [27:0] out_perimeter;
  logic [1:0]  out_status;

  perim_res_t  pending_q[$];
  logic [16:0] sin2_tbl[0:STEPS];
  int          errors = 0;
  int          sent = 0;
  int          got = 0;
  int          n_err_items = 0;
  longint      cycles = 0;
  bit          no_gaps = 1'b0;

  ellipse_perimeter_integrator_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_major_axis(in_major_axis),
    .in_minor_axis(in_minor_axis),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_perimeter(out_perimeter),
    .out_status   (out_status)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    bit          neg;
    x2  = (x * x) >> 30;
    t   = x;
    s   = x;
    neg = 1'b1;
    for (int n = 3; n <= 17; n += 2) begin
      t = ((t * x2) >> 30) / 64'((n - 1) * n);
      if (neg) begin
        s = (s >= t) ? s - t : 64'd0;
      end else begin
        s = s + t;
      end
      neg = ~neg;
    end
    if (s > UNIT30) begin
      s = UNIT30;
    end
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] root_term(input logic [63:0] e2, input int i);
    logic [63:0] p;
    logic [63:0] v;
    p = (e2 * 64'(sin2_tbl[i])) >> 16;
    v = (p < UNIT16) ? UNIT16 - p : 64'd0;
    return int_sqrt(v << 16);
  endfunction

  function automatic perim_res_t ellipse_perimeter(input logic [23:0] maj,
                                                    input logic [23:0] mnr);
    perim_res_t  r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ratio;
    logic [63:0] e2;
    logic [63:0] acc;
    logic [63:0] ell;
    logic [63:0] per;
    a = 64'(maj);
    b = 64'(mnr);
    r.perimeter = '0;
    if (a == 0) begin
      r.status = epi_pkg::ST_MAJOR_ZERO;
      return r;
    end
    if (b > a) begin
      r.status = epi_pkg::ST_MINOR_GT;
      return r;
    end
    ratio = ((b * b) << 16) / (a * a);
    if (ratio > UNIT16) ratio = UNIT16;
    e2  = UNIT16 - ratio;
    acc = (root_term(e2, 0) >> 1) + (root_term(e2, STEPS) >> 1);
    for (int i = 1; i < STEPS; i++) acc = acc + root_term(e2, i);
    ell = ((acc * epi_pkg::HP30) / 64'(STEPS)) >> 30;
    per = (64'd4 * a * ell) >> 16;
    if (per > 64'(epi_pkg::PERIM_MAX)) per = 64'(epi_pkg::PERIM_MAX);
    r.perimeter = per[27:0];
    r.status    = epi_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_axes(input logic [23:0] maj, input logic [23:0] mnr,
                           input perim_res_t exp_res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_major_axis <= maj;
    in_minor_axis <= mnr;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(exp_res);
    sent++;
    if (exp_res.status != epi_pkg::ST_OK) n_err_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall per result, with stretches of none
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    perim_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      got++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer perimeter=%0h status=%0d", $time,
                 out_perimeter, out_status);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (out_perimeter !== exp_res.perimeter) begin
          $display("%0t: perimeter expected %0h actual %0h", $time,
                   exp_res.perimeter, out_perimeter);
          errors++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    perim_res_t  exp_res;
    logic [23:0] maj;
    logic [23:0] mnr;
    int          kind;

    for (int i = 0; i <= STEPS; i++) begin
      logic [63:0] s;
      s = sin_q30((64'(i) * epi_pkg::HP30) / 64'(STEPS));
      sin2_tbl[i] = 17'((s * s) >> 44);
    end

    rows = '{
      '{24'h000000, 24'h000000, 1'b1, '{28'd0, epi_pkg::ST_MAJOR_ZERO}},
      '{24'h000000, 24'hFFFFFF, 1'b1, '{28'd0, epi_pkg::ST_MAJOR_ZERO}},
      '{24'h000001, 24'h000002, 1'b1, '{28'd0, epi_pkg::ST_MINOR_GT}},
      '{24'hFFFFFE, 24'hFFFFFF, 1'b1, '{28'd0, epi_pkg::ST_MINOR_GT}},
      '{24'h7FFFFF, 24'h800000, 1'b1, '{28'd0, epi_pkg::ST_MINOR_GT}},
      '{24'hFFFFFF, 24'hFFFFFF, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'hFFFFFF, 24'h000000, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h000001, 24'h000000, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h000001, 24'h000001, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h000100, 24'h000100, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h000200, 24'h000100, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h010000, 24'h004000, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'hAAAAAA, 24'h555555, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'h555555, 24'h2AAAAA, 1'b0, '{28'd0, epi_pkg::ST_OK}},
      '{24'hFFFFFF, 24'hFFFFFE, 1'b0, '{28'd0, epi_pkg::ST_OK}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    no_gaps = 1'b1;
    foreach (rows[k]) begin
      row = rows[k];
      exp_res = row.typed ? row.res : ellipse_perimeter(row.major, row.minor);
      send_axes(row.major, row.minor, exp_res);
      if (k == 4) no_gaps = 1'b0;
    end

    // hold off until the directed results are all back
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 25 == 0) no_gaps = (n == 50);
      kind = $urandom_range(0, 19);
      maj  = 24'($urandom);
      if (kind == 0) begin
        maj = '0;
        mnr = 24'($urandom);
      end else if (kind <= 2 && maj != 24'hFFFFFF) begin
        mnr = 24'($urandom_range(32'(maj) + 1, 32'hFFFFFF));
      end else begin
        if (kind == 3) maj = 24'($urandom_range(1, 255));
        if (maj == 0) maj = 24'd1;
        mnr = 24'($urandom_range(0, 32'(maj)));
      end
      send_axes(maj, mnr, ellipse_perimeter(maj, mnr));
    end

    wait_drained();
    repeat (50) @(posedge clk);

    $display("covered %0d transfers (%0d error status), %0d results checked",
             sent, n_err_items, got);
    $display("directed axis extremes and both error cases, then random axis pairs");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
